FILE: hdl/crq_pkg.sv
// shared types, constants and codes of the cycle tagged ring queue
package crq_pkg;

    localparam int MAX_ORDER_DEF = 10;
    localparam int DATA_BITS     = 32;
    localparam int ORDER_RST_DEF = 10;

    localparam int ENTRY_W = 64;
    localparam int CNT_W   = 64;
    localparam int DATA_W  = 32;
    localparam int ORDER_W = 4;
    localparam int WIDTH_W = 6;
    localparam int CFG_W   = 6;
    localparam int INDEX_W = 1;
    localparam int STATUS_W = 2;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [INDEX_W-1:0] REG_QUEUE_ORDER = 1'd0;
    localparam logic [INDEX_W-1:0] REG_PAY_WIDTH   = 1'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

    typedef struct packed {
        logic accept;
        logic step;
        logic clear_step;
    } crq_cmd_t;

    typedef struct packed {
        logic step_done;
        logic clear_last;
    } crq_stat_t;

endpackage

FILE: hdl/crq_ctrl.sv
// controller state machine of the cycle tagged ring queue
module crq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  crq_pkg::crq_stat_t stat,
    output crq_pkg::crq_cmd_t  cmd
);
    import crq_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (out_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.step_done)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_we)
        begin
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> state_reg == ST_CLEAR)
        else $error("config write did not start a clearing pass");

    a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_WALK)
        else $error("result raised outside a walk");

    a_accept_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !cfg_we) |=> state_reg == ST_WALK)
        else $error("accepted transaction did not start a walk");

endmodule

FILE: hdl/crq_dp.sv
// datapath of the cycle tagged ring queue: ring memory, counters, config and result
module crq_dp #(
    parameter int MAX_ORDER = crq_pkg::MAX_ORDER_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [crq_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [crq_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          operation,
    input  logic [crq_pkg::DATA_W-1:0]    payload,
    input  crq_pkg::crq_cmd_t             cmd,
    output crq_pkg::crq_stat_t            stat,
    output logic [crq_pkg::STATUS_W-1:0]  status,
    output logic [crq_pkg::DATA_W-1:0]    read_value
);
    import crq_pkg::*;

    localparam int AW    = MAX_ORDER;
    localparam int DEPTH = 1 << MAX_ORDER;
    localparam int ORDER_MAX = (MAX_ORDER > 15) ? 15 : MAX_ORDER;
    localparam int ORDER_RST = (ORDER_MAX < ORDER_RST_DEF) ? ORDER_MAX : ORDER_RST_DEF;

    logic [ENTRY_W-1:0] ring_mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    logic [ORDER_W-1:0]  order_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [CNT_W-1:0]    head_reg;
    logic [CNT_W-1:0]    tail_reg;
    logic [AW-1:0]       step_cnt_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic                op_reg;
    logic [DATA_W-1:0]   payload_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [DATA_W-1:0]   value_reg;

    logic [ORDER_W-1:0]  order_sat;
    logic [WIDTH_W-1:0]  width_sat;
    logic [AW-1:0]       mask;
    logic [CNT_W-1:0]    pos;
    logic [CNT_W-1:0]    pos_inc;
    logic [CNT_W-1:0]    cyc;
    logic [ENTRY_W-1:0]  ent_cyc;
    logic [WIDTH_W-1:0]  shamt;
    logic [ENTRY_W-1:0]  consumed;
    logic [ENTRY_W-1:0]  dmask;
    logic [ENTRY_W-1:0]  cyc_field;
    logic                never_used;
    logic                older;
    logic                same;
    logic                invalid;

    logic                done;
    logic                adv;
    logic                cont;
    logic                step_we;
    logic [ENTRY_W-1:0]  step_wdata;
    logic [STATUS_W-1:0] step_status;
    logic [DATA_W-1:0]   step_value;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [CNT_W-1:0]    acc_pos;

    // register saturation
    always_comb
    begin
        if (cfg_data[ORDER_W-1:0] == '0)
            order_sat = ORDER_W'(1);
        else if (int'(cfg_data[ORDER_W-1:0]) > ORDER_MAX)
            order_sat = ORDER_W'(ORDER_MAX);
        else
            order_sat = cfg_data[ORDER_W-1:0];
        if (cfg_data[WIDTH_W-1:0] == '0)
            width_sat = WIDTH_W'(1);
        else if (int'(cfg_data[WIDTH_W-1:0]) > DATA_BITS)
            width_sat = WIDTH_W'(DATA_BITS);
        else
            width_sat = cfg_data[WIDTH_W-1:0];
    end

    always_comb
    begin
        for (int i = 0; i < AW; i++)
        begin
            mask[i] = (i < int'(order_reg));
        end
    end

    // entry decode
    assign pos        = (op_reg == OP_DEQ) ? head_reg : tail_reg;
    assign pos_inc    = pos + CNT_W'(1);
    assign cyc        = pos >> order_reg;
    assign shamt      = width_reg + WIDTH_W'(1);
    assign ent_cyc    = rdata_reg >> shamt;
    assign consumed   = ENTRY_W'(1) << width_reg;
    assign dmask      = consumed - ENTRY_W'(1);
    assign cyc_field  = cyc << shamt;
    assign never_used = &rdata_reg;
    assign older      = never_used || (ent_cyc < cyc);
    assign same       = !never_used && (ent_cyc == cyc);
    assign invalid    = (payload_reg >> width_reg) != '0;

    // one walk step
    always_comb
    begin
        done        = 1'b0;
        adv         = 1'b0;
        cont        = 1'b0;
        step_we     = 1'b0;
        step_wdata  = cyc_field | consumed;
        step_status = STATUS_OK;
        step_value  = '0;
        if (op_reg == OP_DEQ)
        begin
            if (head_reg == tail_reg)
            begin
                done        = 1'b1;
                step_status = STATUS_EMPTY;
            end
            else if (same)
            begin
                step_we    = 1'b1;
                step_wdata = rdata_reg | consumed;
                adv        = 1'b1;
                done       = 1'b1;
                step_value = rdata_reg[DATA_W-1:0] & dmask[DATA_W-1:0];
            end
            else if (pos_inc == tail_reg)
            begin
                done        = 1'b1;
                step_status = STATUS_EMPTY;
            end
            else
            begin
                step_we = older;
                adv     = 1'b1;
                cont    = 1'b1;
            end
        end
        else
        begin
            if (invalid)
            begin
                done        = 1'b1;
                step_status = STATUS_INVALID;
            end
            else
            begin
                adv = 1'b1;
                if (older && rdata_reg[width_reg])
                begin
                    step_we    = 1'b1;
                    step_wdata = cyc_field | {{(ENTRY_W-DATA_W){1'b0}}, payload_reg};
                    done       = 1'b1;
                end
                else if (step_cnt_reg == mask)
                begin
                    done        = 1'b1;
                    step_status = STATUS_FULL;
                end
                else
                begin
                    cont = 1'b1;
                end
            end
        end
    end

    assign stat.step_done  = done;
    assign stat.clear_last = (clr_cnt_reg == {AW{1'b1}});

    // memory ports
    assign acc_pos   = (operation == OP_DEQ) ? head_reg : tail_reg;
    assign mem_we    = cmd.clear_step || (cmd.step && step_we);
    assign mem_waddr = cmd.clear_step ? clr_cnt_reg : (pos[AW-1:0] & mask);
    assign mem_wdata = cmd.clear_step ? {ENTRY_W{1'b1}} : step_wdata;
    assign mem_re    = cmd.accept || (cmd.step && cont);
    assign mem_raddr = cmd.accept ? (acc_pos[AW-1:0] & mask) : (pos_inc[AW-1:0] & mask);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= ring_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg    <= ORDER_W'(ORDER_RST);
            width_reg    <= WIDTH_W'(DATA_BITS);
            head_reg     <= '0;
            tail_reg     <= '0;
            step_cnt_reg <= '0;
            clr_cnt_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUEUE_ORDER: order_reg <= order_sat;
                REG_PAY_WIDTH:   width_reg <= width_sat;
                default:         ;
            endcase
            head_reg    <= '0;
            tail_reg    <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.accept)
            begin
                step_cnt_reg <= '0;
            end
            if (cmd.step && adv)
            begin
                if (op_reg == OP_DEQ)
                begin
                    head_reg <= pos_inc;
                end
                else
                begin
                    tail_reg     <= pos_inc;
                    step_cnt_reg <= step_cnt_reg + AW'(1);
                end
            end
        end
    end

    // transaction and result holding registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg      <= operation;
            payload_reg <= payload;
        end
        if (cmd.step && done)
        begin
            status_reg <= step_status;
            value_reg  <= step_value;
        end
    end

    assign status     = status_reg;
    assign read_value = value_reg;

    a_value_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && done && op_reg == OP_DEQ && !cfg_we) |=> (value_reg >> width_reg) == '0)
        else $error("dequeued value wider than data width");

    a_one_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && op_reg == OP_ENQ) |-> step_cnt_reg <= mask)
        else $error("enqueue walk went past one ring pass");

    a_read_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (mem_raddr & ~mask) == '0)
        else $error("ring read outside the entries in use");

endmodule

FILE: hdl/cycle_tagged_ring_queue_unit.sv
// top level of the cycle tagged ring queue
// usage:
//   input channel (in_valid/in_ready) carries one transaction: operation 0 enqueues
//   payload, operation 1 dequeues. output channel (out_valid/out_ready) returns one
//   result per transaction: status (0 ok, 1 payload too wide, 2 empty, 3 full) and
//   read_value (dequeued data on a good dequeue, else zero).
//   config port: cfg_we with cfg_index 0 (queue order) or 1 (payload width) and cfg_data.
//   every config write empties the queue and starts a clearing pass.
// timing:
//   the result register loads at the first walk step when the first ring position
//   probed settles the transaction; each skipped position adds one walk step.
//   each probe is a single ring read-modify-write, and a new transaction is accepted
//   only once the walk of the one before it is done.
//   after reset and after each config write the ring is cleared one entry a cycle,
//   all 2^MAX_ORDER entries, with in_ready low.
//   while out_ready is low a finished result waits in the output register; the next
//   transaction is still accepted, but its walk holds until the result is taken.
module cycle_tagged_ring_queue_unit #(
    parameter int MAX_ORDER = crq_pkg::MAX_ORDER_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [crq_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [crq_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [crq_pkg::DATA_W-1:0]    payload,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [crq_pkg::STATUS_W-1:0]  status,
    output logic [crq_pkg::DATA_W-1:0]    read_value
);
    import crq_pkg::*;

    crq_cmd_t  cmd;
    crq_stat_t stat;

    crq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    crq_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .operation  (operation),
        .payload    (payload),
        .cmd        (cmd),
        .stat       (stat),
        .status     (status),
        .read_value (read_value)
    );

endmodule

FILE: bench/crq_checker.sv
`timescale 1ns / 100ps
// checker for the cycle tagged ring queue: watches both channels and predicts each result
module crq_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [crq_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [crq_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          operation,
    input  logic [crq_pkg::DATA_W-1:0]    payload,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [crq_pkg::STATUS_W-1:0]  status,
    input  logic [crq_pkg::DATA_W-1:0]    read_value,
    output int                            fail_count,
    output int                            pending,
    output int                            n_ok,
    output int                            n_invalid,
    output int                            n_empty,
    output int                            n_full
);
    import crq_pkg::*;

    localparam int RING_DEPTH = 1 << MAX_ORDER_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   value;
    } queue_result_t;

    logic [ENTRY_W-1:0] ring_words [0:RING_DEPTH-1];
    logic [CNT_W-1:0]   head_pos;
    logic [CNT_W-1:0]   tail_pos;
    int unsigned        q_order;
    int unsigned        q_width;
    queue_result_t      due_results [$];
    int                 n_results;

    task automatic ring_clear();
        for (int i = 0; i < RING_DEPTH; i++)
            ring_words[i] = '1;
        head_pos = '0;
        tail_pos = '0;
    endtask

    // never-used entries count as older than any cycle
    function automatic logic entry_older(input logic [63:0] ent, input logic [63:0] cyc);
        return (ent == '1) || ((ent >> (q_width + 1)) < cyc);
    endfunction

    task automatic ring_enqueue(input logic [63:0] data, output logic [STATUS_W-1:0] st);
        logic [63:0] tries;
        logic [63:0] mask;
        logic [63:0] pos;
        logic [63:0] cyc;
        logic [63:0] ent;
        logic [63:0] k;
        logic [MAX_ORDER_DEF-1:0] slot;
        st = STATUS_FULL;
        tries = 64'd1 << q_order;
        mask = tries - 64'd1;
        if (data > (64'd1 << q_width) - 64'd1)
            st = STATUS_INVALID;
        else
        begin
            for (k = 0; k < tries && st == STATUS_FULL; k++)
            begin
                pos = tail_pos;
                slot = pos[MAX_ORDER_DEF-1:0] & mask[MAX_ORDER_DEF-1:0];
                ent = ring_words[slot];
                cyc = pos >> q_order;
                tail_pos = pos + 64'd1;
                if (entry_older(ent, cyc) && ent[q_width])
                begin
                    ring_words[slot] = (cyc << (q_width + 1)) | data;
                    st = STATUS_OK;
                end
            end
        end
    endtask

    task automatic ring_dequeue(output logic [STATUS_W-1:0] st, output logic [DATA_W-1:0] val);
        logic [63:0] mask;
        logic [63:0] used_bit;
        logic [63:0] pos;
        logic [63:0] cyc;
        logic [63:0] ent;
        logic [63:0] ent_data;
        logic [MAX_ORDER_DEF-1:0] slot;
        logic walking;
        st = STATUS_EMPTY;
        val = '0;
        mask = (64'd1 << q_order) - 64'd1;
        used_bit = 64'd1 << q_width;
        walking = 1'b1;
        while (walking)
        begin
            pos = head_pos;
            if (pos == tail_pos)
                walking = 1'b0;
            else
            begin
                slot = pos[MAX_ORDER_DEF-1:0] & mask[MAX_ORDER_DEF-1:0];
                ent = ring_words[slot];
                cyc = pos >> q_order;
                if (ent != '1 && (ent >> (q_width + 1)) == cyc)
                begin
                    ring_words[slot] = ent | used_bit;
                    head_pos = pos + 64'd1;
                    ent_data = ent & (used_bit - 64'd1);
                    val = ent_data[DATA_W-1:0];
                    st = STATUS_OK;
                    walking = 1'b0;
                end
                else if (pos + 64'd1 == tail_pos)
                    walking = 1'b0;
                else
                begin
                    // stale entry is retagged as consumed, future entry left alone
                    if (entry_older(ent, cyc))
                        ring_words[slot] = (cyc << (q_width + 1)) | used_bit;
                    head_pos = pos + 64'd1;
                end
            end
        end
    endtask

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] result %0d: %s", $realtime, n_results, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t       want;
        logic [STATUS_W-1:0] st;
        logic [DATA_W-1:0]   val;
        if (!rst_n)
        begin
            q_order = ORDER_RST_DEF;
            q_width = DATA_BITS;
            ring_clear();
            due_results.delete();
            fail_count = 0;
            pending = 0;
            n_results = 0;
            n_ok = 0;
            n_invalid = 0;
            n_empty = 0;
            n_full = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (due_results.size() == 0)
                    flag_error($sformatf("unexpected transaction, status %0d value %h",
                                         status, read_value));
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.status || read_value !== want.value)
                        flag_error($sformatf(
                            "expected status %0d value %h, got status %0d value %h",
                            want.status, want.value, status, read_value));
                end
            end
            if (in_valid && in_ready)
            begin
                val = '0;
                if (operation == OP_DEQ)
                    ring_dequeue(st, val);
                else
                    ring_enqueue({32'd0, payload}, st);
                case (st)
                    STATUS_OK:      n_ok++;
                    STATUS_INVALID: n_invalid++;
                    STATUS_EMPTY:   n_empty++;
                    default:        n_full++;
                endcase
                want.status = st;
                want.value = val;
                due_results.push_back(want);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_QUEUE_ORDER)
                    q_order = (cfg_data[3:0] == 4'd0) ? 1 :
                              (cfg_data[3:0] > MAX_ORDER_DEF) ? MAX_ORDER_DEF : cfg_data[3:0];
                else
                    q_width = (cfg_data == '0) ? 1 :
                              (cfg_data > DATA_BITS) ? DATA_BITS : cfg_data;
                ring_clear();
            end
            pending = due_results.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the cycle tagged ring queue: stimulus, idling and verdict
module tb_top;
    import crq_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                operation = OP_ENQ;
    logic [DATA_W-1:0]   payload = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_value;

    int          fail_count;
    int          pending;
    int          n_ok;
    int          n_invalid;
    int          n_empty;
    int          n_full;
    int          send_idle = 26;
    int          recv_idle = 70;
    int          sent = 0;
    int          n_settings = 0;
    int unsigned cur_width = DATA_BITS;

    cycle_tagged_ring_queue_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .payload    (payload),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .read_value (read_value)
    );

    crq_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .payload    (payload),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .read_value (read_value),
        .fail_count (fail_count),
        .pending    (pending),
        .n_ok       (n_ok),
        .n_invalid  (n_invalid),
        .n_empty    (n_empty),
        .n_full     (n_full)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic op, input logic [DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        payload <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        while (!in_ready)
            @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] order_raw,
                             input logic [CFG_W-1:0] width_raw);
        wait_quiet();
        write_reg(REG_QUEUE_ORDER, order_raw);
        wait_quiet();
        write_reg(REG_PAY_WIDTH, width_raw);
        cur_width = (width_raw == '0) ? 1 : (width_raw > DATA_BITS) ? DATA_BITS : width_raw;
        n_settings++;
    endtask

    function automatic logic [DATA_W-1:0] pick_payload(input int unsigned w);
        logic [DATA_W-1:0] lim;
        lim = 32'hFFFF_FFFF >> (32 - w);
        case ($urandom_range(19))
            0:       return '0;
            1:       return lim;
            2:       return lim + 32'd1;
            3, 4:    return $urandom();
            default: return $urandom() & lim;
        endcase
    endfunction

    initial
    begin
        logic [CFG_W-1:0] ord_raw;
        logic [CFG_W-1:0] wid_raw;
        int               burst_left;
        int               enq_pct;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: default setting, extremes of the payload
        send_item(OP_DEQ, 32'h1234_5678);
        send_item(OP_ENQ, 32'h0000_0000);
        send_item(OP_ENQ, 32'hFFFF_FFFF);
        send_item(OP_ENQ, 32'hA5A5_5A5A);
        send_item(OP_DEQ, '0);
        send_item(OP_DEQ, '0);
        send_item(OP_DEQ, '0);
        send_item(OP_DEQ, '0);

        // directed: order and width below range, too wide, full ring, stale walk
        configure(6'h30, 6'h00);
        send_item(OP_ENQ, 32'h0000_0002);
        send_item(OP_ENQ, 32'hFFFF_FFFF);
        send_item(OP_ENQ, 32'h0000_0001);
        send_item(OP_ENQ, 32'h0000_0000);
        send_item(OP_ENQ, 32'h0000_0001);
        send_item(OP_DEQ, '0);
        send_item(OP_ENQ, 32'h0000_0001);
        send_item(OP_DEQ, '0);
        send_item(OP_DEQ, '0);
        send_item(OP_DEQ, '0);
        send_item(OP_ENQ, 32'h0000_0001);
        send_item(OP_DEQ, '0);
        send_item(OP_DEQ, '0);

        burst_left = 0;
        enq_pct = 50;
        for (int ph = 0; ph < 12; ph++)
        begin
            ord_raw = {2'($urandom_range(3)), 4'($urandom_range(1, 4))};
            wid_raw = 6'($urandom_range(63));
            case (ph)
                0: begin ord_raw = 6'h0F; wid_raw = 6'h3F; end
                3: wid_raw = 6'h00;
                5: ord_raw = 6'h20;
                7: wid_raw = 6'd32;
                9: ord_raw = 6'h1A;
                default: ;
            endcase
            configure(ord_raw, wid_raw);
            send_idle = (ph < 4) ? 26 : (ph < 8) ? 70 : 0;
            recv_idle = (ph < 4) ? 70 : (ph < 8) ? 26 : 0;
            for (int k = 0; k < 154; k++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(30, 6);
                    case ($urandom_range(2))
                        0:       enq_pct = 85;
                        1:       enq_pct = 50;
                        default: enq_pct = 15;
                    endcase
                end
                burst_left--;
                send_item(($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ,
                          pick_payload(cur_width));
            end
        end

        wait_quiet();
        repeat (16) @(negedge clk);
        $display("%0d transactions over %0d register settings", sent, n_settings + 1);
        $display("results: %0d ok, %0d too wide, %0d empty, %0d full",
                 n_ok, n_invalid, n_empty, n_full);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: cycle_tagged_ring_queue_unit.f
hdl/crq_pkg.sv
hdl/crq_ctrl.sv
hdl/crq_dp.sv
hdl/cycle_tagged_ring_queue_unit.sv
bench/crq_checker.sv
bench/tb_top.sv
